[src/u16r_pkg.sv]
// u16r_pkg: shared types and constants of the 16550-style register model.
`timescale 1ns / 1ps
package u16r_pkg;

    // Item commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Register offsets
    localparam logic [2:0] REG_DATA = 3'd0;  // RBR / THR / DLL
    localparam logic [2:0] REG_IER  = 3'd1;  // IER / DLM
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    // Interrupt identification codes
    localparam logic [7:0] IIR_LINE  = 8'h06;
    localparam logic [7:0] IIR_RXDA  = 8'h04;
    localparam logic [7:0] IIR_THRE  = 8'h02;
    localparam logic [7:0] IIR_MODEM = 8'h00;
    localparam logic [7:0] IIR_NONE  = 8'h01;

    // Reset values and masks
    localparam logic [7:0] LSR_RESET     = 8'h60;
    localparam logic [7:0] MSR_RESET     = 8'hf0;
    localparam logic [7:0] LSR_TX_EMPTY  = 8'h60;
    localparam logic [7:0] LSR_READ_KEEP = 8'he1;
    localparam logic [7:0] LSR_ERR_MASK  = 8'h1e;
    localparam logic [7:0] MSR_READ_KEEP = 8'hf0;
    localparam logic [7:0] MSR_DELTA     = 8'h0f;

    // FIFO operation requested by the register file
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_op;

    // FIFO fill flags seen by the register file
    typedef struct packed {
        logic empty;
        logic full;
        logic one;   // exactly one entry held
    } t_fifo_stat;

    // One result before the output register
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
        logic       pop;       // read_data comes from the FIFO memory
    } t_result;

endpackage

[src/uart_16550_register_model.sv]
// uart_16550_register_model: top level of the 16550-style register model.
`timescale 1ns / 1ps
// Each input transfer is a register write, a register read, a received byte or a no-op, and
// produces exactly one output transfer, registered in the cycle after it is taken. One item is taken every
// cycle while the output side accepts; the output register holds one result, so a
// stall on the output stops the input only while that result waits. A data-register
// read pops the receive FIFO, whose memory has a registered read port;
// the popped byte is muxed into the output in the cycle after the transfer. The
// FIFO memory is not cleared after reset and needs no clearing pass.
module uart_16550_register_model #(
    parameter int RX_FIFO_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] command, [4:2] reg_index, [12:5] write_data, [20:13] rx_byte
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] rx_dropped
    output logic [23:0] o_m_axis_tdata
);
    import u16r_pkg::*;

    logic       accept;
    t_fifo_op   fifo_op;
    t_fifo_stat fifo_stat;
    t_result    result;
    t_result    r_out;
    logic       r_out_valid;
    logic [7:0] fifo_q;
    logic [7:0] out_read_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    u16r_reg_file u_reg_file (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_s_axis_tdata[1:0]),
        .i_reg_index  (i_s_axis_tdata[4:2]),
        .i_write_data (i_s_axis_tdata[12:5]),
        .i_fifo_stat  (fifo_stat),
        .o_fifo_op    (fifo_op),
        .o_result     (result)
    );

    u16r_rx_fifo #(
        .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (fifo_op),
        .i_wr_data (i_s_axis_tdata[20:13]),
        .o_stat    (fifo_stat),
        .o_rd_data (fifo_q)
    );

    // Output register; the FIFO read data only changes on the next pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign out_read_data   = r_out.pop ? fifo_q : r_out.read_data;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out.rx_dropped, r_out.tx_byte, r_out.tx_valid,
                              out_read_data};

endmodule

[src/u16r_rx_fifo.sv]
// u16r_rx_fifo: receive FIFO memory with pointers, level and registered read port.
`timescale 1ns / 1ps
module u16r_rx_fifo #(
    parameter int RX_FIFO_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u16r_pkg::t_fifo_op  i_op,
    input  logic [7:0]          i_wr_data,
    output u16r_pkg::t_fifo_stat o_stat,
    output logic [7:0]          o_rd_data
);
    import u16r_pkg::*;

    localparam int AW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int LW = $clog2(RX_FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(RX_FIFO_DEPTH - 1);

    logic [7:0]    r_mem [RX_FIFO_DEPTH];
    logic [7:0]    r_q;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [LW-1:0] r_level;

    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == LW'(RX_FIFO_DEPTH));
    assign o_stat.one   = (r_level == LW'(1));
    assign o_rd_data    = r_q;

    // Storage: write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (i_op.pop) begin
            r_q <= r_mem[r_rd_ptr];
        end
    end

    // Pointers and level; push and pop never come together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_op.push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
                r_level  <= r_level + LW'(1);
            end else if (i_op.pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
                r_level  <= r_level - LW'(1);
            end
        end
    end

endmodule

[src/u16r_reg_file.sv]
// u16r_reg_file: control and status registers, access decode and FIFO requests.
`timescale 1ns / 1ps
module u16r_reg_file (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_command,
    input  logic [2:0]           i_reg_index,
    input  logic [7:0]           i_write_data,
    input  u16r_pkg::t_fifo_stat i_fifo_stat,
    output u16r_pkg::t_fifo_op   o_fifo_op,
    output u16r_pkg::t_result    o_result
);
    import u16r_pkg::*;

    logic [7:0] r_lcr, n_lcr;
    logic [3:0] r_ier, n_ier;
    logic [4:0] r_mcr, n_mcr;
    logic [7:0] r_scr, n_scr;
    logic [7:0] r_dll, n_dll;
    logic [7:0] r_dlm, n_dlm;
    logic [7:0] r_lsr, n_lsr;
    logic [7:0] r_msr, n_msr;
    logic       r_thre_ack, n_thre_ack;
    logic       dlab;
    t_result    res;
    t_fifo_op   op;

    assign dlab = r_lcr[7];

    // Decode one item: next register values, result and FIFO request
    always_comb begin
        n_lcr      = r_lcr;
        n_ier      = r_ier;
        n_mcr      = r_mcr;
        n_scr      = r_scr;
        n_dll      = r_dll;
        n_dlm      = r_dlm;
        n_lsr      = r_lsr;
        n_msr      = r_msr;
        n_thre_ack = r_thre_ack;
        res        = '0;
        op         = '0;
        unique case (i_command)
            CMD_WRITE: begin
                unique case (i_reg_index)
                    REG_DATA: begin
                        if (dlab) begin
                            n_dll = i_write_data;
                        end else begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = i_write_data;
                            n_thre_ack   = 1'b0;
                        end
                    end
                    REG_IER: begin
                        if (dlab) n_dlm = i_write_data;
                        else      n_ier = i_write_data[3:0];
                    end
                    REG_LCR: n_lcr = i_write_data;
                    REG_MCR: n_mcr = i_write_data[4:0];
                    REG_SCR: n_scr = i_write_data;
                    default: ;  // IIR, LSR, MSR are read only
                endcase
            end
            CMD_READ: begin
                unique case (i_reg_index)
                    REG_DATA: begin
                        if (dlab) begin
                            res.read_data = r_dll;
                        end else begin
                            // pop; data arrives from the memory next cycle
                            op.pop   = !i_fifo_stat.empty;
                            res.pop  = !i_fifo_stat.empty;
                            n_lsr[0] = !i_fifo_stat.empty && !i_fifo_stat.one;
                            if (r_mcr[4]) begin
                                n_lsr[6:5] = 2'b00;
                            end
                        end
                    end
                    REG_IER: res.read_data = dlab ? r_dlm : {4'b0, r_ier};
                    REG_IIR: begin
                        priority if (r_ier[2] && ((r_lsr & LSR_ERR_MASK) != '0)) begin
                            res.read_data = IIR_LINE;
                        end else if (r_ier[0] && r_lsr[0]) begin
                            res.read_data = IIR_RXDA;
                        end else if (r_ier[1] && !r_thre_ack) begin
                            res.read_data = IIR_THRE;
                            n_thre_ack    = 1'b1;
                        end else if (r_ier[3] && ((r_msr & MSR_DELTA) != '0)) begin
                            res.read_data = IIR_MODEM;
                        end else begin
                            res.read_data = IIR_NONE;
                        end
                    end
                    REG_LCR: res.read_data = r_lcr;
                    REG_MCR: res.read_data = {3'b0, r_mcr};
                    REG_LSR: begin
                        res.read_data = r_lsr | LSR_TX_EMPTY;
                        n_lsr         = r_lsr & LSR_READ_KEEP;
                    end
                    REG_MSR: begin
                        res.read_data = r_msr;
                        n_msr         = r_msr & MSR_READ_KEEP;
                    end
                    REG_SCR: res.read_data = r_scr;
                    default: ;
                endcase
            end
            CMD_RX: begin
                // FIFO holds at least one byte afterwards either way
                op.push        = !i_fifo_stat.full;
                res.rx_dropped = i_fifo_stat.full;
                n_lsr[0]       = 1'b1;
            end
            CMD_NONE: ;
            default: ;
        endcase
    end

    assign o_result    = res;
    assign o_fifo_op.push = i_accept && op.push;
    assign o_fifo_op.pop  = i_accept && op.pop;

    // Register update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcr      <= '0;
            r_ier      <= '0;
            r_mcr      <= '0;
            r_scr      <= '0;
            r_dll      <= '0;
            r_dlm      <= '0;
            r_lsr      <= LSR_RESET;
            r_msr      <= MSR_RESET;
            r_thre_ack <= 1'b0;
        end else if (i_accept) begin
            r_lcr      <= n_lcr;
            r_ier      <= n_ier;
            r_mcr      <= n_mcr;
            r_scr      <= n_scr;
            r_dll      <= n_dll;
            r_dlm      <= n_dlm;
            r_lsr      <= n_lsr;
            r_msr      <= n_msr;
            r_thre_ack <= n_thre_ack;
        end
    end

endmodule
